>>> rtl/glob_wildcard_matcher_defines.svh
// Assertion helpers for the matcher RTL.
`ifndef GLOB_WILDCARD_MATCHER_DEFINES_SVH
`define GLOB_WILDCARD_MATCHER_DEFINES_SVH

// Same-cycle implication, quiet while reset is held.
`define GWM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, quiet while reset is held.
`define GWM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/gwm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package gwm_pkg;

    localparam int MAX_PATTERN = 64;
    localparam int LEN_W       = $clog2(MAX_PATTERN + 1);

    localparam logic [7:0] CH_ANY_ONE = 8'h3F;
    localparam logic [7:0] CH_ANY_RUN = 8'h2A;

    typedef enum logic [1:0] {
        REQ_APPEND = 2'd0,
        REQ_CLEAR  = 2'd1,
        REQ_NAME   = 2'd2,
        REQ_END    = 2'd3
    } t_req;

    // broadcast to every cell
    typedef struct packed {
        logic       rearm;
        logic       consume;
        logic       clear;
        logic [7:0] fchar;
    } t_cell_ctl;

    // ASCII A-Z to a-z only
    function automatic logic [7:0] fold_case(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= 8'h41 && c <= 8'h5A) begin
            r = c + 8'h20;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> rtl/glob_wildcard_matcher.sv
`timescale 1ns / 1ps
`default_nettype none
// Case-insensitive wildcard matcher ('*' any run, '?' any one char).
// Slave stream: tuser is the request kind (append pattern char, clear
// pattern, name char, end of name), tdata the character byte.
// Load a pattern with append requests, then stream a name as name-char
// requests closed by end of name. Only end of name produces a result on
// the master stream: tdata bit 0 matched, bit 1 pattern overflow.
// One request per cycle is sustained unless a held result stalls. The
// live-position vector sits in a row of one cell per pattern position and
// each name char updates the whole row at once, stars rippling
// their live bit forward along the row.
// The result is registered and appears in the cycle after the end-of-name request.
// Stall: the result is held in an output register; a new request is still
// taken while the held result goes out in the same cycle, else the slave
// side stalls.
// Reset: pattern empty, overflow clear, matcher armed, no result pending.
// Append or clear restarts any name in progress.

`include "glob_wildcard_matcher_defines.svh"

module glob_wildcard_matcher (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_s_tvalid,
    output logic            o_s_tready,
    input  wire logic [7:0] i_s_tdata,  // [7:0] char_code
    input  wire logic [1:0] i_s_tuser,  // [1:0] req_type
    output logic            o_m_tvalid,
    input  wire logic       i_m_tready,
    output logic [7:0]      o_m_tdata   // [0] matched, [1] pattern_overflow, [7:2] zero
);

    localparam int MAXP = gwm_pkg::MAX_PATTERN;

    logic                        w_acc;
    gwm_pkg::t_req               w_req;
    logic                        w_full;
    logic                        w_is_end;
    gwm_pkg::t_cell_ctl          w_ctl;
    logic [MAXP:0]               w_carry;
    logic [MAXP:0]               w_step;
    logic [MAXP:0]               w_closed;
    logic [MAXP-1:0]             w_wr;
    logic                        w_hit;

    logic [gwm_pkg::LEN_W-1:0]   r_len;
    logic                        r_ovf;
    logic                        r_live_end;
    logic                        r_out_valid;
    logic                        r_matched;
    logic                        r_out_ovf;

    assign o_s_tready = !r_out_valid || i_m_tready;
    assign w_acc      = i_s_tvalid && o_s_tready;
    assign w_req      = gwm_pkg::t_req'(i_s_tuser);
    assign w_full     = (r_len == gwm_pkg::LEN_W'(MAXP));

    always_comb begin
        w_ctl          = '0;
        w_ctl.fchar    = gwm_pkg::fold_case(i_s_tdata);
        w_is_end       = 1'b0;
        unique case (w_req)
            gwm_pkg::REQ_APPEND: w_ctl.rearm = w_acc;
            gwm_pkg::REQ_CLEAR: begin
                w_ctl.rearm = w_acc;
                w_ctl.clear = w_acc;
            end
            gwm_pkg::REQ_NAME: w_ctl.consume = w_acc;
            gwm_pkg::REQ_END: begin
                w_ctl.rearm = w_acc;
                w_is_end    = w_acc;
            end
            default: w_ctl.rearm = 1'b0;
        endcase
    end

    assign w_carry[0] = 1'b0;
    assign w_step[0]  = 1'b0;

    for (genvar p = 0; p < MAXP; p++) begin : g_cell
        assign w_wr[p] = w_acc && (w_req == gwm_pkg::REQ_APPEND) &&
                         (r_len == gwm_pkg::LEN_W'(p));
        gwm_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctl    (w_ctl),
            .i_wr     (w_wr[p]),
            .i_seed   (1'(p == 0)),
            .i_carry  (w_carry[p]),
            .i_step   (w_step[p]),
            .o_carry  (w_carry[p+1]),
            .o_step   (w_step[p+1]),
            .o_closed (w_closed[p])
        );
    end

    // position past a full pattern
    assign w_closed[MAXP] = r_live_end | w_carry[MAXP];
    assign w_hit          = w_closed[r_len] && !r_ovf;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= '0;
            r_ovf       <= 1'b0;
            r_live_end  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_ctl.clear) begin
                r_len <= '0;
                r_ovf <= 1'b0;
            end else if (w_acc && w_req == gwm_pkg::REQ_APPEND) begin
                if (w_full) begin
                    r_ovf <= 1'b1;
                end else begin
                    r_len <= r_len + 1'b1;
                end
            end
            if (w_ctl.rearm) begin
                r_live_end <= 1'b0;
            end else if (w_ctl.consume) begin
                r_live_end <= w_step[MAXP];
            end
            if (w_is_end) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_is_end) begin
            r_matched <= w_hit;
            r_out_ovf <= r_ovf;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {6'b0, r_out_ovf, r_matched};

    `GWM_ASSERT_NOW(a_ovf_no_match, o_m_tvalid && o_m_tdata[1], !o_m_tdata[0], "match with overflow")
    `GWM_ASSERT_NOW(a_len_range, 1'b1, r_len <= gwm_pkg::LEN_W'(MAXP), "pattern length out of range")
    `GWM_ASSERT_NEXT(a_clear, w_ctl.clear, r_len == '0 && !r_ovf, "clear not applied")
    `GWM_ASSERT_NEXT(a_end_result, w_is_end, o_m_tvalid, "end of name gave no result")
    `GWM_ASSERT_NOW(a_no_loss, o_m_tvalid && !i_m_tready, !w_acc, "request taken over held result")

endmodule

`default_nettype wire

>>> rtl/gwm_cell.sv
`timescale 1ns / 1ps
`default_nettype none

// One pattern position: stored (folded) char, in-pattern flag, live bit.
module gwm_cell (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire gwm_pkg::t_cell_ctl i_ctl,
    input  wire logic               i_wr,
    input  wire logic               i_seed,
    input  wire logic               i_carry,
    input  wire logic               i_step,
    output logic                    o_carry,
    output logic                    o_step,
    output logic                    o_closed
);

    logic [7:0] r_char;
    logic       r_en;
    logic       r_live;
    logic       n_live;
    logic       w_star;

    assign w_star   = (r_char == gwm_pkg::CH_ANY_RUN);
    // a live star ahead of us makes this position live too
    assign o_closed = r_live | i_carry;
    assign o_carry  = o_closed & r_en & w_star;
    assign o_step   = o_closed & r_en &
                      ((r_char == gwm_pkg::CH_ANY_ONE) || (r_char == i_ctl.fchar));
    assign n_live   = o_carry | i_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_en   <= 1'b0;
            r_live <= i_seed;
        end else begin
            if (i_ctl.clear) begin
                r_en <= 1'b0;
            end else if (i_wr) begin
                r_en <= 1'b1;
            end
            if (i_ctl.rearm) begin
                r_live <= i_seed;
            end else if (i_ctl.consume) begin
                r_live <= n_live;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_char <= i_ctl.fchar;
        end
    end

endmodule

`default_nettype wire
